@@ sv/fmrf_pkg.sv @@
// Shared types, opcodes and the rule match function for the rule filter.
`timescale 1ns / 1ps
`default_nettype none
package fmrf_pkg;

    localparam int RULE_DEPTH_DEF = 32;
    // Width that the count and index comparisons are widened to.
    localparam int CMP_W = 16;

    localparam logic [1:0] OP_CLASSIFY = 2'd0;
    localparam logic [1:0] OP_APPEND   = 2'd1;
    localparam logic [1:0] OP_REMOVE   = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] FLAG_SYN  = 8'h02;
    localparam logic [7:0] FLAG_ACK  = 8'h10;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] src_addr;
        logic [31:0] src_mask;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [31:0] dst_mask;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic        drop_rule;
        logic [7:0]  tcp_flags;
        logic [4:0]  rule_index;
    } t_in_word;

    typedef struct packed {
        logic       verdict;
        logic       status;
        logic [5:0] rule_total;
    } t_out_word;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] src_mask;
        logic [31:0] dst_addr;
        logic [31:0] dst_mask;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic        drop;
    } t_rule;

    localparam int RULE_W = $bits(t_rule);

    // Front to back handshake
    typedef struct packed {
        logic valid;
        logic take;
    } t_cmd_hs;

    // Returns {hit, drop} for one rule against one packet header.
    function automatic logic [1:0] rule_match(input t_rule r, input t_in_word p);
        logic ret;
        logic src_ok;
        logic dst_ok;
        logic port_ok;
        logic [31:0] dtest;
        logic [15:0] psp;
        logic [15:0] pdp;
        logic proto_ok;
        logic not_bare_syn;
        begin
            proto_ok = (r.protocol == 8'd0) || (r.protocol == p.protocol);
            src_ok = (r.src_addr == 32'd0) || ((p.src_addr & r.src_mask) == r.src_addr);
            not_bare_syn = ((p.tcp_flags & FLAG_SYN) == 8'd0) ||
                ((p.tcp_flags & (FLAG_SYN | FLAG_ACK)) == (FLAG_SYN | FLAG_ACK));
            ret = !src_ok && (p.protocol == PROTO_TCP) && not_bare_syn &&
                ((p.dst_addr & r.src_mask) == r.src_addr);
            dtest = ret ? p.src_addr : p.dst_addr;
            dst_ok = (r.dst_addr == 32'd0) || ((dtest & r.dst_mask) == r.dst_addr);
            psp = ret ? p.dst_port : p.src_port;
            pdp = ret ? p.src_port : p.dst_port;
            port_ok = 1'b1;
            if ((p.protocol == PROTO_TCP) || (p.protocol == PROTO_UDP)) begin
                port_ok = ((r.src_port == 16'd0) || (psp == r.src_port)) &&
                          ((r.dst_port == 16'd0) || (pdp == r.dst_port));
            end
            rule_match = {proto_ok && (src_ok || ret) && dst_ok && port_ok, r.drop};
        end
    endfunction

endpackage
`default_nettype wire

@@ sv/first_match_ip_rule_filter_core.sv @@
// Top level of the first-match IP rule filter.
`timescale 1ns / 1ps
`default_nettype none
// Keeps an ordered table of up to RULE_DEPTH rules in one RAM and answers
// every input word with one result word. A two-word input queue feeds a
// sequential rule engine, which holds one result word until it is popped.
// Classify reads and checks one rule at a time through the single read port,
// up to the first match; remove moves each rule after the removed one down
// one place. The RAM needs no clearing after reset: only entries below the
// rule count are read.
module first_match_ip_rule_filter_core #(
    parameter int RULE_DEPTH = fmrf_pkg::RULE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire fmrf_pkg::t_in_word i_in_word,
    output logic                    empty,
    input  wire logic               pop,
    output fmrf_pkg::t_out_word     o_out_word
);

    fmrf_pkg::t_cmd_hs  hs;
    fmrf_pkg::t_in_word cmd;
    logic               take;

    fmrf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_in_word(i_in_word),
        .i_take   (take),
        .o_hs     (hs),
        .o_cmd    (cmd)
    );

    fmrf_engine #(.RULE_DEPTH(RULE_DEPTH)) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hs      (hs),
        .i_cmd     (cmd),
        .o_take    (take),
        .empty     (empty),
        .pop       (pop),
        .o_out_word(o_out_word)
    );

endmodule
`default_nettype wire

@@ sv/fmrf_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module fmrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ sv/fmrf_front.sv @@
// Front end: two-word input queue that decouples the link from the rule engine.
`timescale 1ns / 1ps
`default_nettype none
module fmrf_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire fmrf_pkg::t_in_word i_in_word,
    input  wire logic              i_take,
    output fmrf_pkg::t_cmd_hs      o_hs,
    output fmrf_pkg::t_in_word     o_cmd
);

    fmrf_pkg::t_in_word r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign full  = (r_cnt == 2'd2);
    assign wr    = push && !full;
    assign rd    = i_take && (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];
    assign o_hs.valid = (r_cnt != 2'd0);
    assign o_hs.take  = rd;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_in_word;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule
`default_nettype wire

@@ sv/fmrf_engine.sv @@
// Back end: walks the rule table for classify and remove, holds the result word.
`timescale 1ns / 1ps
`default_nettype none
module fmrf_engine #(
    parameter int RULE_DEPTH = fmrf_pkg::RULE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fmrf_pkg::t_cmd_hs  i_hs,
    input  wire fmrf_pkg::t_in_word i_cmd,
    output logic                    o_take,
    output logic                    empty,
    input  wire logic               pop,
    output fmrf_pkg::t_out_word     o_out_word
);

    localparam int AW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int CW = $clog2(RULE_DEPTH + 1);
    localparam logic [fmrf_pkg::CMP_W-1:0] DEPTH_EXT = fmrf_pkg::CMP_W'(RULE_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_CRD  = 3'd2;
    localparam logic [2:0] S_CCHK = 3'd3;
    localparam logic [2:0] S_SRD  = 3'd4;
    localparam logic [2:0] S_SWR  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_ptr, n_ptr;
    logic                 r_verdict, n_verdict;
    logic                 r_status, n_status;
    fmrf_pkg::t_in_word   r_cmd;
    logic                 r_out_valid, n_out_valid;
    fmrf_pkg::t_out_word  r_out, n_out;

    logic                 wr_en, rd_en;
    logic [AW-1:0]        wr_addr, rd_addr;
    fmrf_pkg::t_rule      wr_rule, rd_rule;
    logic [fmrf_pkg::RULE_W-1:0] rd_bits;
    logic [1:0]           hit;
    logic [fmrf_pkg::CMP_W-1:0] cnt_ext, ptr_ext, idx_ext;

    fmrf_ram #(.WIDTH(fmrf_pkg::RULE_W), .DEPTH(RULE_DEPTH)) u_rules (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_rule),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_bits)
    );

    assign rd_rule = rd_bits;
    assign hit     = fmrf_pkg::rule_match(rd_rule, r_cmd);
    assign cnt_ext = fmrf_pkg::CMP_W'(r_count);
    assign ptr_ext = fmrf_pkg::CMP_W'(r_ptr);
    assign idx_ext = fmrf_pkg::CMP_W'(r_cmd.rule_index);
    assign o_take  = (r_state == S_IDLE) && i_hs.valid;
    assign empty   = !r_out_valid;
    assign o_out_word = r_out;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_verdict   = r_verdict;
        n_status    = r_status;
        n_out_valid = r_out_valid && !pop;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_ptr;
        wr_rule     = rd_rule;
        rd_en       = 1'b0;
        rd_addr     = r_ptr;
        case (r_state)
            S_IDLE: begin
                if (i_hs.valid) n_state = S_DISP;
            end
            S_DISP: begin
                n_verdict = 1'b0;
                n_status  = 1'b0;
                n_state   = S_DONE;
                case (r_cmd.opcode)
                    fmrf_pkg::OP_CLASSIFY: begin
                        n_ptr = '0;
                        if (r_count != '0) n_state = S_CRD;
                    end
                    fmrf_pkg::OP_APPEND: begin
                        if (cnt_ext >= DEPTH_EXT) begin
                            n_status = 1'b1;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = r_count[AW-1:0];
                            wr_rule.src_addr = r_cmd.src_addr;
                            wr_rule.src_mask = r_cmd.src_mask;
                            wr_rule.dst_addr = r_cmd.dst_addr;
                            wr_rule.dst_mask = r_cmd.dst_mask;
                            wr_rule.src_port = r_cmd.src_port;
                            wr_rule.dst_port = r_cmd.dst_port;
                            wr_rule.protocol = r_cmd.protocol;
                            wr_rule.drop     = r_cmd.drop_rule;
                            n_count = r_count + CW'(1);
                        end
                    end
                    fmrf_pkg::OP_REMOVE: begin
                        if (idx_ext < cnt_ext) begin
                            n_ptr = AW'(r_cmd.rule_index);
                            if (idx_ext + 1'b1 < cnt_ext) begin
                                n_state = S_SRD;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                    end
                    default: begin
                        n_count = '0;
                    end
                endcase
            end
            S_CRD: begin
                rd_en   = 1'b1;
                n_state = S_CCHK;
            end
            S_CCHK: begin
                if (hit[1]) begin
                    n_verdict = hit[0];
                    n_state   = S_DONE;
                end else if (ptr_ext + 1'b1 >= cnt_ext) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr   = r_ptr + AW'(1);
                    n_state = S_CRD;
                end
            end
            S_SRD: begin
                rd_en   = 1'b1;
                rd_addr = r_ptr + AW'(1);
                n_state = S_SWR;
            end
            S_SWR: begin
                wr_en = 1'b1;
                n_ptr = r_ptr + AW'(1);
                if (ptr_ext + 2'd2 >= cnt_ext) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || pop) begin
                    n_out_valid       = 1'b1;
                    n_out.verdict     = r_verdict;
                    n_out.status      = r_status;
                    n_out.rule_total  = cnt_ext[5:0];
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_verdict <= n_verdict;
        r_status  <= n_status;
        r_out     <= n_out;
        if (o_take) r_cmd <= i_cmd;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fmrf_pkg::CMP_W'(r_count) <= DEPTH_EXT)
        else $error("rule count beyond table depth");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWR) |-> (ptr_ext + 1'b1 < cnt_ext))
        else $error("shift copies from beyond the last rule");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status) |-> (cnt_ext == DEPTH_EXT))
        else $error("full status with room in the table");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> (r_state == S_DISP))
        else $error("word taken outside idle");

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the first-match IP rule filter core.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    localparam int DEPTH = fmrf_pkg::RULE_DEPTH_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int IN_W = $bits(fmrf_pkg::t_in_word);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    fmrf_pkg::t_in_word i_in_word = '0;
    fmrf_pkg::t_out_word o_out_word;

    // Shadow copy of the rule table
    fmrf_pkg::t_rule shadow_rules[DEPTH];
    int unsigned shadow_count = 0;
    fmrf_pkg::t_out_word expected_words[$];
    int unsigned errors = 0;
    int unsigned words_sent = 0;
    int unsigned words_checked = 0;
    int unsigned idle_cycles = 0;
    bit pop_enable = 1'b0;

    first_match_ip_rule_filter_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_in_word(i_in_word), .empty(empty), .pop(pop), .o_out_word(o_out_word)
    );

    always #5 i_clk = ~i_clk;

    // One rule against one header; returns {hit, drop}
    function automatic logic [1:0] rule_hits(input fmrf_pkg::t_rule r,
                                             input fmrf_pkg::t_in_word p);
        logic swapped;
        logic [31:0] dcheck;
        logic [15:0] sp_cmp;
        logic [15:0] dp_cmp;
        logic not_bare_syn;
        if (r.protocol != 8'd0 && r.protocol != p.protocol) return 2'b00;
        swapped = 1'b0;
        if (r.src_addr != 32'd0 && (p.src_addr & r.src_mask) != r.src_addr) begin
            not_bare_syn = !p.tcp_flags[1] || (p.tcp_flags[1] && p.tcp_flags[4]);
            if (p.protocol == fmrf_pkg::PROTO_TCP && not_bare_syn &&
                (p.dst_addr & r.src_mask) == r.src_addr)
                swapped = 1'b1;
            else
                return 2'b00;
        end
        dcheck = swapped ? p.src_addr : p.dst_addr;
        if (r.dst_addr != 32'd0 && (dcheck & r.dst_mask) != r.dst_addr) return 2'b00;
        if (p.protocol == fmrf_pkg::PROTO_TCP || p.protocol == fmrf_pkg::PROTO_UDP) begin
            sp_cmp = swapped ? p.dst_port : p.src_port;
            dp_cmp = swapped ? p.src_port : p.dst_port;
            if (r.src_port != 16'd0 && sp_cmp != r.src_port) return 2'b00;
            if (r.dst_port != 16'd0 && dp_cmp != r.dst_port) return 2'b00;
        end
        return {1'b1, r.drop};
    endfunction

    // Updates the shadow table and yields the result word for one input word
    function automatic fmrf_pkg::t_out_word filter_outcome(input fmrf_pkg::t_in_word w);
        fmrf_pkg::t_out_word res;
        logic [1:0] m;
        res = '0;
        case (w.opcode)
            fmrf_pkg::OP_CLASSIFY: begin
                for (int i = 0; i < shadow_count; i++) begin
                    m = rule_hits(shadow_rules[i], w);
                    if (m[1]) begin
                        res.verdict = m[0];
                        break;
                    end
                end
            end
            fmrf_pkg::OP_APPEND: begin
                if (shadow_count >= DEPTH) begin
                    res.status = 1'b1;
                end else begin
                    shadow_rules[shadow_count] = '{src_addr: w.src_addr,
                        src_mask: w.src_mask, dst_addr: w.dst_addr,
                        dst_mask: w.dst_mask, src_port: w.src_port,
                        dst_port: w.dst_port, protocol: w.protocol,
                        drop: w.drop_rule};
                    shadow_count++;
                end
            end
            fmrf_pkg::OP_REMOVE: begin
                if (w.rule_index < shadow_count) begin
                    for (int i = w.rule_index; i + 1 < shadow_count; i++)
                        shadow_rules[i] = shadow_rules[i + 1];
                    shadow_count--;
                end
            end
            default: shadow_count = 0;
        endcase
        res.rule_total = shadow_count[5:0];
        return res;
    endfunction

    // Random gap, mostly short with the odd long one
    function automatic int unsigned gap_length();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one word and records its expected result; push stays high into
    // the next word when there is no gap
    task automatic send_word(input fmrf_pkg::t_in_word w);
        int unsigned gap;
        gap = gap_length();
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        expected_words.push_back(filter_outcome(w));
        words_sent++;
    endtask

    // Result checker and pop driver
    always @(posedge i_clk) begin
        fmrf_pkg::t_out_word exp_w;
        if (pop && !empty) begin
            words_checked++;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, o_out_word);
                errors++;
            end else begin
                exp_w = expected_words.pop_front();
                if (o_out_word.verdict !== exp_w.verdict)
                    $display("%0t: verdict expected %0d actual %0d", $time,
                             exp_w.verdict, o_out_word.verdict);
                if (o_out_word.status !== exp_w.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_w.status, o_out_word.status);
                if (o_out_word.rule_total !== exp_w.rule_total)
                    $display("%0t: rule_total expected %0d actual %0d", $time,
                             exp_w.rule_total, o_out_word.rule_total);
                if (o_out_word !== exp_w) errors++;
            end
        end
        if (!pop_enable) begin
            pop <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0: pop <= 1'b0;
                1, 2, 3: pop <= (pop ? 1'($urandom_range(0, 1)) : 1'b0);
                default: pop <= 1'b1;
            endcase
        end
    end

    // Long receiver stalls now and then
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                pop_enable = 1'b1;
                if ($urandom_range(0, 199) == 0) begin
                    pop_enable = 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
                    pop_enable = 1'b1;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic fmrf_pkg::t_in_word blank_word(input logic [1:0] op);
        fmrf_pkg::t_in_word w;
        w = '0;
        w.opcode = op;
        return w;
    endfunction

    function automatic fmrf_pkg::t_in_word random_word();
        fmrf_pkg::t_in_word w;
        w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        return w;
    endfunction

    // Rule built around a small address/port pool so packets hit often
    function automatic fmrf_pkg::t_in_word pool_rule();
        fmrf_pkg::t_in_word w;
        w = random_word();
        w.opcode = fmrf_pkg::OP_APPEND;
        w.src_mask = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'hFFFF_FF00;
        w.dst_mask = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'hFFFF_FF00;
        w.src_addr = $urandom_range(0, 2) == 0 ? 32'd0 :
                     {24'h0A0000, 6'd0, 2'($urandom)} & w.src_mask;
        w.dst_addr = $urandom_range(0, 2) == 0 ? 32'd0 :
                     {24'h0A0001, 6'd0, 2'($urandom)} & w.dst_mask;
        w.src_port = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 3));
        w.dst_port = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 3));
        case ($urandom_range(0, 3))
            0: w.protocol = 8'd0;
            1: w.protocol = fmrf_pkg::PROTO_TCP;
            2: w.protocol = fmrf_pkg::PROTO_UDP;
            default: w.protocol = 8'($urandom);
        endcase
        return w;
    endfunction

    function automatic fmrf_pkg::t_in_word pool_packet();
        fmrf_pkg::t_in_word w;
        w = random_word();
        w.opcode = fmrf_pkg::OP_CLASSIFY;
        if ($urandom_range(0, 1)) begin
            w.src_addr = {24'h0A0000, 6'd0, 2'($urandom)};
            w.dst_addr = {24'h0A0001, 6'd0, 2'($urandom)};
        end else begin
            w.src_addr = {24'h0A0001, 6'd0, 2'($urandom)};
            w.dst_addr = {24'h0A0000, 6'd0, 2'($urandom)};
        end
        w.src_port = 16'($urandom_range(1, 3));
        w.dst_port = 16'($urandom_range(1, 3));
        w.protocol = $urandom_range(0, 2) == 0 ? fmrf_pkg::PROTO_UDP :
                     ($urandom_range(0, 4) == 0 ? 8'($urandom) : fmrf_pkg::PROTO_TCP);
        case ($urandom_range(0, 3))
            0: w.tcp_flags = fmrf_pkg::FLAG_SYN;
            1: w.tcp_flags = fmrf_pkg::FLAG_SYN | fmrf_pkg::FLAG_ACK;
            2: w.tcp_flags = fmrf_pkg::FLAG_ACK;
            default: w.tcp_flags = 8'($urandom);
        endcase
        return w;
    endfunction

    // Extremes, wildcards, return traffic and table edge cases
    task automatic test_directed();
        fmrf_pkg::t_in_word w;
        send_word(blank_word(fmrf_pkg::OP_CLASSIFY));
        send_word(blank_word(fmrf_pkg::OP_REMOVE));
        w = blank_word(fmrf_pkg::OP_APPEND);
        w.src_addr = 32'h0A00_0001; w.src_mask = '1;
        w.dst_addr = 32'h0A00_0002; w.dst_mask = '1;
        w.src_port = 16'd80; w.dst_port = 16'hFFFF;
        w.protocol = fmrf_pkg::PROTO_TCP; w.drop_rule = 1'b1;
        send_word(w);
        w = blank_word(fmrf_pkg::OP_CLASSIFY);
        w.src_addr = 32'h0A00_0001; w.dst_addr = 32'h0A00_0002;
        w.src_port = 16'd80; w.dst_port = 16'hFFFF; w.protocol = fmrf_pkg::PROTO_TCP;
        send_word(w);
        // return traffic, ACK set, then bare SYN which must not match
        w.src_addr = 32'h0A00_0002; w.dst_addr = 32'h0A00_0001;
        w.src_port = 16'hFFFF; w.dst_port = 16'd80; w.tcp_flags = fmrf_pkg::FLAG_ACK;
        send_word(w);
        w.tcp_flags = fmrf_pkg::FLAG_SYN;
        send_word(w);
        w.tcp_flags = fmrf_pkg::FLAG_SYN | fmrf_pkg::FLAG_ACK;
        send_word(w);
        w.protocol = fmrf_pkg::PROTO_UDP;
        send_word(w);
        w = random_word();
        w.opcode = fmrf_pkg::OP_APPEND; w.protocol = 8'd0; w.drop_rule = 1'b0;
        send_word(w);
        send_word('1);
        // fill to full, overflow, then removes at both ends and past end
        for (int i = 0; i < DEPTH + 1; i++) begin
            w = random_word();
            w.opcode = fmrf_pkg::OP_APPEND;
            send_word(w);
        end
        w = random_word(); w.opcode = fmrf_pkg::OP_CLASSIFY; send_word(w);
        w = blank_word(fmrf_pkg::OP_REMOVE); w.rule_index = 5'd31; send_word(w);
        w.rule_index = 5'd0; send_word(w);
        w.rule_index = 5'd31; send_word(w);
        send_word(blank_word(fmrf_pkg::OP_CLEAR));
    endtask

    // Rule tables built from a small pool with many matching packets
    task automatic test_random_tables();
        int unsigned r;
        fmrf_pkg::t_in_word w;
        for (int n = 0; n < 700; n++) begin
            r = $urandom_range(0, 99);
            if (r < 55) w = pool_packet();
            else if (r < 80) w = pool_rule();
            else if (r < 88) begin
                w = random_word(); w.opcode = fmrf_pkg::OP_REMOVE;
                w.rule_index = 5'($urandom_range(0, shadow_count + 2));
            end else if (r < 90) w = blank_word(fmrf_pkg::OP_CLEAR);
            else w = random_word();
            send_word(w);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_tables();
        push <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d words, checked %0d results: classify, append, remove,",
                 words_sent, words_checked);
        $display("clear, table full and return-traffic cases covered.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
